>>> hw/rtl/maze_cell_map_dead_end_engine_macros.svh
// ----------------------------------------------------------------------------
// Maze cell map assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef MAZE_CELL_MAP_DEAD_END_ENGINE_MACROS_SVH
`define MAZE_CELL_MAP_DEAD_END_ENGINE_MACROS_SVH

// same-cycle implication
`define MCM_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define MCM_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> hw/rtl/mcm_pkg.sv
// ----------------------------------------------------------------------------
// Maze cell map package
// Field widths, operation, direction, edge and status codes, edge helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 5;
  localparam int DIR_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 8;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int EDGE_W    = 2;
  localparam int NUM_DIRS  = 4;
  localparam int EDGES_W   = EDGE_W * NUM_DIRS;

  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [OP_W-1:0] OP_PLACE = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WALL  = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd3;

  localparam logic [EDGE_W-1:0] EDGE_UNKNOWN = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_WALL    = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_OPEN    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_DEAD = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXIT     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_EXIT  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OFF_GRID = 3'd4;

  function automatic logic [EDGE_W-1:0] get_edge(input logic [EDGES_W-1:0] e,
                                                 input logic [DIR_W-1:0] d);
    return e[d*EDGE_W +: EDGE_W];
  endfunction

  function automatic logic [EDGES_W-1:0] set_edge(input logic [EDGES_W-1:0] e,
                                                  input logic [DIR_W-1:0] d,
                                                  input logic [EDGE_W-1:0] code);
    logic [EDGES_W-1:0] r;
    r = e;
    r[d*EDGE_W +: EDGE_W] = code;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_ram #(
  parameter int WIDTH  = 18,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/maze_cell_map_dead_end_engine.sv
// ----------------------------------------------------------------------------
// Maze cell map dead-end engine
// Grid map of maze cells with place, move, add-wall and dead-end check.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Its result word
// appears for exactly one cycle with done high and must be taken then; the
// block cannot be stalled on the result side. All cell state sits in one RAM
// with a single read port, read one cell per cycle and written back one cell
// per cycle, so the cost is set by the cells touched: place reads and writes
// the cell, move and add-wall also the neighbor (add-wall writes none on the
// border), check-dead-end the cell and its four neighbors, off-grid requests
// none. After reset the block clears all MAX_SIDE*MAX_SIDE cells (1024 by
// default) one cell per cycle, with busy high; register writes are taken at
// any time, but only while idle do they act cleanly.
// ----------------------------------------------------------------------------
`default_nettype none

`include "maze_cell_map_dead_end_engine_macros.svh"

module maze_cell_map_dead_end_engine #(
  parameter int MAX_SIDE   = 32,
  parameter int VISIT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcm_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcm_pkg::OP_W-1:0]        op,
  input  logic [mcm_pkg::COORD_W-1:0]     cell_x,
  input  logic [mcm_pkg::COORD_W-1:0]     cell_y,
  input  logic [mcm_pkg::DIR_W-1:0]       direction,
  output logic                            done,
  output logic [mcm_pkg::STATUS_W-1:0]    status,
  output logic [mcm_pkg::DIR_W-1:0]       exit_dir,
  output logic [mcm_pkg::COUNT_W-1:0]     visit_count
);

  import mcm_pkg::*;

  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int VIS_LO   = EDGES_W;
  localparam int CUR_BIT  = EDGES_W + VISIT_BITS;
  localparam int DEAD_BIT = CUR_BIT + 1;
  localparam int WORD_W   = DEAD_BIT + 1;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_W    = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
  localparam int PROD_W   = ADDR_W + COORD_W + 1;
  localparam int VW8      = (VISIT_BITS > COUNT_W) ? VISIT_BITS : COUNT_W;
  localparam logic [VISIT_BITS-1:0] VMAX = '1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_WR_C  = 6'b010000,
    ST_WR_N  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]    grid_width, grid_height;
  logic [CMP_W-1:0]    eff_w, eff_h, in_x, in_y;
  logic                in_off, move_bad, accept;
  logic [NUM_DIRS-1:0] in_nvld;
  logic [ADDR_W-1:0]   in_addr;

  logic [OP_W-1:0]     op_q;
  logic [DIR_W-1:0]    dir_q;
  logic [ADDR_W-1:0]   c_addr;
  logic [NUM_DIRS-1:0] nvld;
  logic [2:0]          last_slot, rd_idx, cap_idx;
  logic                cap_vld;
  logic [WORD_W-1:0]   c_word, n_word;
  logic [NUM_DIRS-1:0] n_dead;
  logic [ADDR_W-1:0]   clr_addr;

  logic [ADDR_W-1:0]   nbr_addr [NUM_DIRS];
  logic [DIR_W-1:0]    rd_dir;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                ram_we, ram_re;
  logic [WORD_W-1:0]   wr_data, rd_data;

  logic [EDGES_W-1:0]    c_edges, n_edges;
  logic [VISIT_BITS-1:0] c_vis, n_vis_inc;
  logic [NUM_DIRS-1:0]   blocked;
  logic [2:0]            blk_cnt;
  logic                  is_dead, has_exit, need_n;
  logic [DIR_W-1:0]      exit_k;
  logic [WORD_W-1:0]     c_new, n_new;
  logic [STATUS_W-1:0]   res_status;
  logic [DIR_W-1:0]      res_exit;
  logic [COUNT_W-1:0]    res_count;

  function automatic logic [COUNT_W-1:0] shown(input logic [VISIT_BITS-1:0] v);
    logic [VW8-1:0] e;
    e = VW8'(v);
    return (e > VW8'(8'hFF)) ? 8'hFF : e[COUNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_wr_data;
        REG_GRID_HEIGHT: grid_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = CMP_W'(grid_width);
    eff_h = CMP_W'(grid_height);
    if (eff_w == '0) eff_w = CMP_W'(1);
    else if (eff_w > CMP_W'(MAX_SIDE)) eff_w = CMP_W'(MAX_SIDE);
    if (eff_h == '0) eff_h = CMP_W'(1);
    else if (eff_h > CMP_W'(MAX_SIDE)) eff_h = CMP_W'(MAX_SIDE);
  end

  assign in_x   = CMP_W'(cell_x);
  assign in_y   = CMP_W'(cell_y);
  assign in_off = (in_x >= eff_w) || (in_y >= eff_h);
  assign in_nvld[DIR_WEST]  = (in_x != '0);
  assign in_nvld[DIR_NORTH] = (in_y != '0);
  assign in_nvld[DIR_SOUTH] = ((in_y + CMP_W'(1)) < eff_h);
  assign in_nvld[DIR_EAST]  = ((in_x + CMP_W'(1)) < eff_w);
  assign move_bad = (op == OP_MOVE) && !in_nvld[direction];
  assign in_addr  = ADDR_W'(PROD_W'(cell_y) * PROD_W'(MAX_SIDE) + PROD_W'(cell_x));
  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);

  assign nbr_addr[DIR_WEST]  = c_addr - ADDR_W'(1);
  assign nbr_addr[DIR_NORTH] = c_addr - ADDR_W'(MAX_SIDE);
  assign nbr_addr[DIR_SOUTH] = c_addr + ADDR_W'(MAX_SIDE);
  assign nbr_addr[DIR_EAST]  = c_addr + ADDR_W'(1);

  assign rd_dir  = (op_q == OP_CHECK) ? DIR_W'(rd_idx - 3'd1) : dir_q;
  assign rd_addr = (rd_idx == 3'd0 || !nvld[rd_dir]) ? c_addr : nbr_addr[rd_dir];
  assign ram_re  = (state == ST_READ);

  always_comb begin
    ram_we  = 1'b0;
    wr_addr = c_addr;
    wr_data = c_new;
    unique case (state)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_WR_C: ram_we = 1'b1;
      ST_WR_N: begin
        ram_we  = 1'b1;
        wr_addr = nbr_addr[dir_q];
        wr_data = n_new;
      end
      default: ;
    endcase
  end

  mcm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_cell_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ram_re),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign c_edges = c_word[EDGES_W-1:0];
  assign c_vis   = c_word[VIS_LO +: VISIT_BITS];
  assign n_edges = n_word[EDGES_W-1:0];
  assign n_vis_inc = (n_word[VIS_LO +: VISIT_BITS] == VMAX) ?
                     VMAX : n_word[VIS_LO +: VISIT_BITS] + VISIT_BITS'(1);

  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      blocked[k] = (get_edge(c_edges, DIR_W'(k)) == EDGE_WALL) || !nvld[k] || n_dead[k];
    end
  end

  assign blk_cnt  = 3'($countones(blocked));
  assign is_dead  = (blk_cnt > 3'd2);
  assign has_exit = !(&blocked);

  always_comb begin
    exit_k = DIR_WEST;
    for (int k = NUM_DIRS - 1; k >= 0; k--) begin
      if (!blocked[k]) exit_k = DIR_W'(k);
    end
  end

  assign need_n = (op_q == OP_MOVE) || ((op_q == OP_WALL) && nvld[dir_q]);

  always_comb begin
    c_new      = c_word;
    n_new      = n_word;
    res_status = STATUS_DONE;
    res_exit   = DIR_WEST;
    res_count  = shown(c_vis);
    unique case (op_q)
      OP_PLACE: begin
        c_new     = {c_word[DEAD_BIT], 1'b1, VISIT_BITS'(1), c_edges};
        res_count = shown(VISIT_BITS'(1));
      end
      OP_MOVE: begin
        c_new     = {c_word[DEAD_BIT], 1'b0, c_vis, set_edge(c_edges, dir_q, EDGE_OPEN)};
        n_new     = {n_word[DEAD_BIT], 1'b1, n_vis_inc, set_edge(n_edges, ~dir_q, EDGE_OPEN)};
        res_count = shown(n_vis_inc);
      end
      OP_WALL: begin
        c_new = {c_word[DEAD_BIT], c_word[CUR_BIT], c_vis, set_edge(c_edges, dir_q, EDGE_WALL)};
        n_new = {n_word[DEAD_BIT], n_word[CUR_BIT], n_word[VIS_LO +: VISIT_BITS],
                 set_edge(n_edges, ~dir_q, EDGE_WALL)};
      end
      OP_CHECK: begin
        c_new[DEAD_BIT] = c_word[DEAD_BIT] | is_dead;
        if (!is_dead) begin
          res_status = STATUS_NOT_DEAD;
        end else if (has_exit) begin
          res_status = STATUS_EXIT;
          res_exit   = exit_k;
        end else begin
          res_status = STATUS_NO_EXIT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && !(in_off || move_bad)) state_next = ST_READ;
      ST_READ:  if (rd_idx == last_slot) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_WR_C;
      ST_WR_C:  state_next = need_n ? ST_WR_N : ST_IDLE;
      ST_WR_N:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      cap_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cap_vld  <= (state == ST_READ);
      done     <= (accept && (in_off || move_bad)) || (state == ST_WR_N) ||
                  ((state == ST_WR_C) && !need_n);
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= rd_idx;
    if (accept) begin
      op_q    <= op;
      dir_q   <= direction;
      c_addr  <= in_addr;
      nvld    <= in_nvld;
      rd_idx  <= 3'd0;
      if (op == OP_CHECK) last_slot <= 3'd4;
      else if (op == OP_PLACE) last_slot <= 3'd0;
      else last_slot <= 3'd1;
      status      <= STATUS_OFF_GRID;
      exit_dir    <= DIR_WEST;
      visit_count <= '0;
    end
    if (state == ST_READ) rd_idx <= rd_idx + 3'd1;
    if (cap_vld) begin
      if (cap_idx == 3'd0) c_word <= rd_data;
      else if (op_q == OP_CHECK) n_dead[DIR_W'(cap_idx - 3'd1)] <= rd_data[DEAD_BIT];
      else n_word <= rd_data;
    end
    if (state == ST_WR_C) begin
      status      <= res_status;
      exit_dir    <= res_exit;
      visit_count <= res_count;
    end
  end

  `MCM_ASSERT_NOW(a_done_idle, done, !busy, "result word while busy")
  `MCM_ASSERT_NEXT(a_off_grid, accept && in_off, done && (status == STATUS_OFF_GRID), "off-grid word lost")
  `MCM_ASSERT_NOW(a_wr_n_op, state == ST_WR_N, (op_q == OP_MOVE) || (op_q == OP_WALL), "neighbor write for wrong op")

endmodule

`default_nettype wire
